// ===== rtl/implicit_array_bst_engine_assert.svh =====
// ----------------------------------------------------------------------------
// implicit_array_bst_engine_assert.svh
// assertion macros for the tree engine
// ----------------------------------------------------------------------------
`ifndef IMPLICIT_ARRAY_BST_ENGINE_ASSERT_SVH
`define IMPLICIT_ARRAY_BST_ENGINE_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define IABST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// follow-up check on the next clock
`define IABST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/iabst_pkg.sv =====
// ----------------------------------------------------------------------------
// iabst_pkg
// types and codes of the implicit array search tree engine
// ----------------------------------------------------------------------------
package iabst_pkg;

   localparam int KEY_W  = 32;
   localparam int SLOT_W = 10;

   localparam logic [1:0] REQ_SEARCH = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_SPARE  = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOT_FND  = 2'd1;
   localparam logic [1:0] STAT_DUP      = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot_index;
      logic [1:0]        status;
   } rsp_item_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DECIDE,
      ST_RM_LRD,
      ST_RM_LCHK,
      ST_RM_RRD,
      ST_RM_RCHK,
      ST_SUCC_RD,
      ST_SUCC_CHK,
      ST_KEY_RD,
      ST_KEY_WR,
      ST_DROP_CLR,
      ST_LIFT_RD,
      ST_LIFT_WR,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/iabst_ram.sv =====
// ----------------------------------------------------------------------------
// iabst_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module iabst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1023
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/implicit_array_bst_engine.sv =====
// ----------------------------------------------------------------------------
// implicit_array_bst_engine
// binary search tree of signed keys held in implicit heap order in memory
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per request, req_type 0 search, 1 insert, 2 remove
//   rsp channel: one item per request with found, slot_index and status
//   slot i has children 2i+1 (smaller keys) and 2i+2 (larger keys)
// sequence
//   the walk reads the memory and then compares for each visited slot
//   (ST_WALK_RD, ST_WALK_CHK); for a search or an insert, ST_DECIDE and
//   then ST_FIN follow, and ST_FIN loads the result into the output
//   register; the next item can be taken in the cycle after that load
//   a remove adds probes of both children and the successor chain, then
//   moves the lifted subtree one slot at a time, with a read and a write
//   state per slot (ST_LIFT_RD, ST_LIFT_WR)
//   one item is worked at a time; the single read port of the key and
//   valid memories paces each step
// reset
//   after reset the valid memory is swept to zero, one slot per cycle over
//   all 2^TREE_LEVELS-1 slots, while req_ready is low
// stalls
//   the result sits in an output register; the next item is taken while it
//   waits, and that item's result waits in its final state for the register
// ----------------------------------------------------------------------------
module implicit_array_bst_engine #(
   parameter int TREE_LEVELS = 10,
   parameter int KEY_BITS    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iabst_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iabst_pkg::rsp_item_type rsp_item
);

`include "implicit_array_bst_engine_assert.svh"

   localparam int NSLOTS = (1 << TREE_LEVELS) - 1;
   localparam int AW     = TREE_LEVELS;
   localparam int IW     = TREE_LEVELS + 3;
   localparam int TW     = (KEY_BITS < iabst_pkg::KEY_W) ? KEY_BITS : iabst_pkg::KEY_W;
   localparam logic [IW-1:0] N_IW   = IW'(NSLOTS);
   localparam logic [AW-1:0] LAST_A = AW'(NSLOTS - 1);

   iabst_pkg::state_type state_ff, state_in;

   logic [IW-1:0] cur_ff, cur_in, last_ff, last_in;
   logic [IW-1:0] succ_ff, succ_in;
   logic [IW-1:0] dbase_ff, dbase_in, sbase_ff, sbase_in;
   logic [IW-1:0] k_ff, k_in, wid_ff, wid_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          hit_ff, hit_in, off_ff, off_in;
   logic          lv_ff, lv_in, rv_ff, rv_in, si_ok_ff, si_ok_in;
   logic [1:0]    op_ff, op_in, status_ff, status_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   iabst_pkg::rsp_item_type    rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic [AW-1:0]       rd_addr;
   logic                v_we, k_we;
   logic [AW-1:0]       v_waddr, k_waddr;
   logic                v_wdata, v_rdata;
   logic [KEY_BITS-1:0] k_wdata, k_rdata;

   logic signed [TW-1:0] key_trim;
   logic [IW-1:0]        lchild, rchild, succ_l, di, si;
   logic                 req_fire, load_rsp;

   iabst_ram #(.WIDTH(1), .DEPTH(NSLOTS)) u_valid_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (rd_addr),
      .rd_data (v_rdata)
   );

   iabst_ram #(.WIDTH(KEY_BITS), .DEPTH(NSLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (k_wdata),
      .rd_addr (rd_addr),
      .rd_data (k_rdata)
   );

   assign key_trim = req_item.key[TW-1:0];
   assign req_ready = (state_ff == iabst_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign lchild    = (cur_ff << 1) + IW'(1);
   assign rchild    = (cur_ff << 1) + IW'(2);
   assign succ_l    = (succ_ff << 1) + IW'(1);
   assign di        = dbase_ff + k_ff;
   assign si        = sbase_ff + k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iabst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      succ_ff   <= succ_in;
      dbase_ff  <= dbase_in;
      sbase_ff  <= sbase_in;
      k_ff      <= k_in;
      wid_ff    <= wid_in;
      hit_ff    <= hit_in;
      off_ff    <= off_in;
      lv_ff     <= lv_in;
      rv_ff     <= rv_in;
      si_ok_ff  <= si_ok_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      succ_in      = succ_ff;
      dbase_in     = dbase_ff;
      sbase_in     = sbase_ff;
      k_in         = k_ff;
      wid_in       = wid_ff;
      clr_in       = clr_ff;
      hit_in       = hit_ff;
      off_in       = off_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      si_ok_in     = si_ok_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = cur_ff[AW-1:0];
      v_we         = 1'b0;
      v_waddr      = cur_ff[AW-1:0];
      v_wdata      = 1'b0;
      k_we         = 1'b0;
      k_waddr      = cur_ff[AW-1:0];
      k_wdata      = key_ff;
      load_rsp     = 1'b0;

      case (state_ff)
         iabst_pkg::ST_CLEAR: begin
            // sweep the valid memory to an empty tree
            v_we    = 1'b1;
            v_waddr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_A) begin
               state_in = iabst_pkg::ST_IDLE;
            end
         end
         iabst_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_item.req_type;
               key_in   = KEY_BITS'(key_trim);
               cur_in   = '0;
               last_in  = '0;
               hit_in   = 1'b0;
               off_in   = 1'b0;
               state_in = iabst_pkg::ST_WALK_RD;
            end
         end
         iabst_pkg::ST_WALK_RD: begin
            if (cur_ff >= N_IW) begin
               off_in   = 1'b1;
               state_in = iabst_pkg::ST_DECIDE;
            end else begin
               state_in = iabst_pkg::ST_WALK_CHK;
            end
         end
         iabst_pkg::ST_WALK_CHK: begin
            if (!v_rdata) begin
               state_in = iabst_pkg::ST_DECIDE;
            end else if ($signed(k_rdata) == key_ff) begin
               hit_in   = 1'b1;
               state_in = iabst_pkg::ST_DECIDE;
            end else begin
               last_in  = cur_ff;
               cur_in   = (key_ff < $signed(k_rdata)) ? lchild : rchild;
               state_in = iabst_pkg::ST_WALK_RD;
            end
         end
         iabst_pkg::ST_DECIDE: begin
            state_in = iabst_pkg::ST_FIN;
            case (op_ff)
               iabst_pkg::REQ_INSERT: begin
                  if (hit_ff) begin
                     status_in = iabst_pkg::STAT_DUP;
                  end else if (off_ff) begin
                     status_in = iabst_pkg::STAT_FULL;
                  end else begin
                     status_in = iabst_pkg::STAT_OK;
                     v_we      = 1'b1;
                     v_wdata   = 1'b1;
                     k_we      = 1'b1;
                  end
               end
               iabst_pkg::REQ_REMOVE: begin
                  status_in = hit_ff ? iabst_pkg::STAT_OK : iabst_pkg::STAT_NOT_FND;
                  if (hit_ff) begin
                     state_in = iabst_pkg::ST_RM_LRD;
                  end
               end
               default: begin
                  status_in = hit_ff ? iabst_pkg::STAT_OK : iabst_pkg::STAT_NOT_FND;
               end
            endcase
         end
         iabst_pkg::ST_RM_LRD: begin
            rd_addr = lchild[AW-1:0];
            if (lchild >= N_IW) begin
               lv_in    = 1'b0;
               state_in = iabst_pkg::ST_RM_RRD;
            end else begin
               state_in = iabst_pkg::ST_RM_LCHK;
            end
         end
         iabst_pkg::ST_RM_LCHK: begin
            lv_in    = v_rdata;
            state_in = iabst_pkg::ST_RM_RRD;
         end
         iabst_pkg::ST_RM_RRD: begin
            rd_addr = rchild[AW-1:0];
            if (rchild >= N_IW) begin
               rv_in    = 1'b0;
               state_in = iabst_pkg::ST_RM_RCHK;
            end else begin
               rv_in    = 1'b1;
               state_in = iabst_pkg::ST_RM_RCHK;
            end
         end
         iabst_pkg::ST_RM_RCHK: begin
            // rv_ff here only says whether the read was in range
            if (lv_ff && rv_ff && v_rdata) begin
               succ_in  = rchild;
               state_in = iabst_pkg::ST_SUCC_RD;
            end else if (lchild >= N_IW) begin
               succ_in  = cur_ff;
               state_in = iabst_pkg::ST_DROP_CLR;
            end else begin
               // lift the only child subtree (the empty right one if there is no child) into the removed slot
               dbase_in = cur_ff;
               sbase_in = lv_ff ? lchild : rchild;
               k_in     = '0;
               wid_in   = IW'(1);
               state_in = iabst_pkg::ST_LIFT_RD;
            end
         end
         iabst_pkg::ST_SUCC_RD: begin
            rd_addr = succ_l[AW-1:0];
            state_in = (succ_l >= N_IW) ? iabst_pkg::ST_KEY_RD : iabst_pkg::ST_SUCC_CHK;
         end
         iabst_pkg::ST_SUCC_CHK: begin
            if (v_rdata) begin
               succ_in  = succ_l;
               state_in = iabst_pkg::ST_SUCC_RD;
            end else begin
               state_in = iabst_pkg::ST_KEY_RD;
            end
         end
         iabst_pkg::ST_KEY_RD: begin
            rd_addr  = succ_ff[AW-1:0];
            state_in = iabst_pkg::ST_KEY_WR;
         end
         iabst_pkg::ST_KEY_WR: begin
            // successor key replaces the removed key, then the successor goes
            k_we    = 1'b1;
            k_wdata = k_rdata;
            if (succ_l >= N_IW) begin
               state_in = iabst_pkg::ST_DROP_CLR;
            end else begin
               dbase_in = succ_ff;
               sbase_in = succ_l + IW'(1);
               k_in     = '0;
               wid_in   = IW'(1);
               state_in = iabst_pkg::ST_LIFT_RD;
            end
         end
         iabst_pkg::ST_DROP_CLR: begin
            v_we     = 1'b1;
            v_waddr  = succ_ff[AW-1:0];
            state_in = iabst_pkg::ST_FIN;
         end
         iabst_pkg::ST_LIFT_RD: begin
            rd_addr  = si[AW-1:0];
            si_ok_in = (si < N_IW);
            if (dbase_ff >= N_IW) begin
               state_in = iabst_pkg::ST_FIN;
            end else if (di >= N_IW) begin
               dbase_in = (dbase_ff << 1) + IW'(1);
               sbase_in = (sbase_ff << 1) + IW'(1);
               wid_in   = wid_ff << 1;
               k_in     = '0;
            end else begin
               state_in = iabst_pkg::ST_LIFT_WR;
            end
         end
         iabst_pkg::ST_LIFT_WR: begin
            v_we     = 1'b1;
            v_waddr  = di[AW-1:0];
            v_wdata  = si_ok_ff && v_rdata;
            k_we     = si_ok_ff && v_rdata;
            k_waddr  = di[AW-1:0];
            k_wdata  = k_rdata;
            state_in = iabst_pkg::ST_LIFT_RD;
            if (k_ff + IW'(1) == wid_ff) begin
               dbase_in = (dbase_ff << 1) + IW'(1);
               sbase_in = (sbase_ff << 1) + IW'(1);
               wid_in   = wid_ff << 1;
               k_in     = '0;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         iabst_pkg::ST_FIN: begin
            // the output register is only touched once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp          = 1'b1;
               rsp_in.found      = hit_ff;
               rsp_in.slot_index = iabst_pkg::SLOT_W'(off_ff ? last_ff : cur_ff);
               rsp_in.status     = status_ff;
               rsp_valid_in      = 1'b1;
               state_in          = iabst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iabst_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a result only lands in a free output register
   `IABST_ASSERT(a_rsp_free, clock, reset, load_rsp |-> (!rsp_valid_ff || rsp_ready), "rsp overwrite")
   // an accepted item starts the walk at the root
   `IABST_ASSERT_NEXT(a_walk_start, clock, reset, req_fire, (state_ff == iabst_pkg::ST_WALK_RD) && (cur_ff == '0), "walk start")
   // no item is taken during the clearing sweep
   `IABST_ASSERT(a_clear_block, clock, reset, (state_ff == iabst_pkg::ST_CLEAR) |-> !req_ready, "req during clear")
   // lifted slots always lie inside the tree
   `IABST_ASSERT(a_lift_range, clock, reset, (state_ff == iabst_pkg::ST_LIFT_WR) |-> (di < N_IW), "lift out of range")

endmodule

// ===== tb/implicit_array_bst_engine_tb.sv =====
// ----------------------------------------------------------------------------
// implicit_array_bst_engine_tb
// self-checking bench for the implicit array search tree engine
// ----------------------------------------------------------------------------
// a local tree model in heap order tracks every accepted item and queues the
// expected response; responses are checked field by field in arrival order.
// directed tests cover empty tree, duplicates, extreme keys, three remove
// shapes and a right spine, then a long random run mixes fill and drain phases
// ----------------------------------------------------------------------------
module implicit_array_bst_engine_tb;

   localparam int LEVELS = 10;
   localparam int SLOTS  = (1 << LEVELS) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   iabst_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   iabst_pkg::rsp_item_type rsp_item;

   // model of the tree contents
   logic signed [iabst_pkg::KEY_W-1:0] tree_key [SLOTS];
   bit                                 tree_used [SLOTS];

   iabst_pkg::rsp_item_type expected_rsp_q [$];
   int  mismatch_count = 0;
   bit  no_idle = 1'b0;
   int  shape_keys [8] = '{50, 30, 70, 20, 40, 60, 80, 65};

   implicit_array_bst_engine #(.TREE_LEVELS(LEVELS), .KEY_BITS(iabst_pkg::KEY_W)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   function automatic bit node_at(int idx);
      return idx < SLOTS && tree_used[idx];
   endfunction

   // replace subtree at dst with the subtree at its child src, level by level
   function automatic void lift_subtree(int dst, int src);
      int width, d_base, s_base;
      width = 1;
      d_base = dst;
      s_base = src;
      while (d_base < SLOTS) begin
         for (int k = 0; k < width; k++) begin
            if (d_base + k >= SLOTS) break;
            if (node_at(s_base + k)) begin
               tree_key[d_base + k]  = tree_key[s_base + k];
               tree_used[d_base + k] = 1'b1;
            end else begin
               tree_used[d_base + k] = 1'b0;
            end
         end
         d_base = 2 * d_base + 1;
         s_base = 2 * s_base + 1;
         width *= 2;
      end
   endfunction

   // delete a node with at most one child
   function automatic void drop_node(int idx);
      if (2 * idx + 1 >= SLOTS) begin
         tree_used[idx] = 1'b0;
      end else begin
         lift_subtree(idx, node_at(2 * idx + 1) ? 2 * idx + 1 : 2 * idx + 2);
      end
   endfunction

   // walk the tree for one item, apply it and return the response
   function automatic iabst_pkg::rsp_item_type tree_apply(iabst_pkg::req_item_type it);
      iabst_pkg::rsp_item_type r;
      int cur, last, succ;
      bit hit, off_end;
      cur = 0; last = 0; hit = 0; off_end = 0;
      forever begin
         if (cur >= SLOTS) begin
            off_end = 1;
            break;
         end
         if (!tree_used[cur]) break;
         if (tree_key[cur] == it.key) begin
            hit = 1;
            break;
         end
         last = cur;
         cur = (it.key < tree_key[cur]) ? 2 * cur + 1 : 2 * cur + 2;
      end
      r.found = hit;
      r.slot_index = iabst_pkg::SLOT_W'(off_end ? last : cur);
      if (it.req_type == iabst_pkg::REQ_INSERT) begin
         if (hit) r.status = iabst_pkg::STAT_DUP;
         else if (off_end) r.status = iabst_pkg::STAT_FULL;
         else begin
            tree_key[cur]  = it.key;
            tree_used[cur] = 1'b1;
            r.status = iabst_pkg::STAT_OK;
         end
      end else if (it.req_type == iabst_pkg::REQ_REMOVE) begin
         if (hit) begin
            if (node_at(2 * cur + 1) && node_at(2 * cur + 2)) begin
               // two children: pull in the successor, then delete it
               succ = 2 * cur + 2;
               while (node_at(2 * succ + 1)) succ = 2 * succ + 1;
               tree_key[cur] = tree_key[succ];
               drop_node(succ);
            end else begin
               drop_node(cur);
            end
            r.status = iabst_pkg::STAT_OK;
         end else begin
            r.status = iabst_pkg::STAT_NOT_FND;
         end
      end else begin
         // search, and the unused code behaves as a search
         r.status = hit ? iabst_pkg::STAT_OK : iabst_pkg::STAT_NOT_FND;
      end
      return r;
   endfunction

   // send one item; entered and left just after a falling edge
   task automatic send_item(logic [1:0] op, logic signed [iabst_pkg::KEY_W-1:0] k);
      iabst_pkg::req_item_type it;
      while (!no_idle && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      it.req_type = op;
      it.key = k;
      req_valid = 1'b1;
      req_item = it;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(tree_apply(it));
      @(negedge clock);
   endtask

   // empty the tree by removing the root until nothing is left
   task automatic drain_tree();
      while (tree_used[0]) send_item(iabst_pkg::REQ_REMOVE, tree_key[0]);
   endtask

   task automatic test_empty_and_extremes();
      send_item(iabst_pkg::REQ_SEARCH, 5);      // miss at empty root
      send_item(iabst_pkg::REQ_REMOVE, 5);      // remove miss
      send_item(iabst_pkg::REQ_INSERT, 5);
      send_item(iabst_pkg::REQ_INSERT, 5);      // duplicate
      send_item(iabst_pkg::REQ_SEARCH, 5);
      send_item(iabst_pkg::REQ_SPARE, 5);       // unused code acts as search
      send_item(iabst_pkg::REQ_INSERT, 32'sh8000_0000);
      send_item(iabst_pkg::REQ_INSERT, 32'sh7fff_ffff);
      send_item(iabst_pkg::REQ_SEARCH, 32'sh8000_0000);
      send_item(iabst_pkg::REQ_SEARCH, 32'sh7fff_ffff);
   endtask

   task automatic test_remove_shapes();
      drain_tree();
      foreach (shape_keys[i]) send_item(iabst_pkg::REQ_INSERT, shape_keys[i]);
      send_item(iabst_pkg::REQ_REMOVE, 20);     // leaf
      send_item(iabst_pkg::REQ_REMOVE, 60);     // right child only
      send_item(iabst_pkg::REQ_REMOVE, 50);     // two children, successor copied up
      send_item(iabst_pkg::REQ_REMOVE, 30);     // right child only after the above
      send_item(iabst_pkg::REQ_SEARCH, 65);
   endtask

   task automatic test_full_level();
      drain_tree();
      // ascending keys build a right spine down to the last level
      for (int i = 1; i <= LEVELS; i++) send_item(iabst_pkg::REQ_INSERT, i);
      send_item(iabst_pkg::REQ_INSERT, LEVELS + 1);   // past last level
      send_item(iabst_pkg::REQ_SEARCH, LEVELS + 1);
      send_item(iabst_pkg::REQ_REMOVE, LEVELS + 1);
      send_item(iabst_pkg::REQ_REMOVE, 1);            // root lift of the whole spine
   endtask

   function automatic logic signed [iabst_pkg::KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 85) return $signed($urandom_range(120)) - 60;
      if (sel < 95) return $urandom;
      case ($urandom_range(3))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic test_random(int count);
      int sel;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= 800 && n < 1100);
         sel = $urandom_range(99);
         // alternate insert heavy and remove heavy phases
         if ((n / 400) % 2 == 0)
            op = sel < 55 ? iabst_pkg::REQ_INSERT : sel < 75 ? iabst_pkg::REQ_REMOVE :
                 sel < 95 ? iabst_pkg::REQ_SEARCH : iabst_pkg::REQ_SPARE;
         else
            op = sel < 20 ? iabst_pkg::REQ_INSERT : sel < 70 ? iabst_pkg::REQ_REMOVE :
                 sel < 95 ? iabst_pkg::REQ_SEARCH : iabst_pkg::REQ_SPARE;
         // about half of the removes aim at the root key, which is present
         if (op == iabst_pkg::REQ_REMOVE && tree_used[0] && $urandom_range(1))
            send_item(op, tree_key[0]);
         else
            send_item(op, pick_key());
      end
      no_idle = 1'b0;
   endtask

   // response side stalls at random, except while no_idle is set
   always @(negedge clock) rsp_ready <= no_idle || ($urandom_range(99) >= 19);

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      iabst_pkg::rsp_item_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %p", rsp_item);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_item.found !== exp_rsp.found ||
                rsp_item.slot_index !== exp_rsp.slot_index ||
                rsp_item.status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected found %0d slot %0d status %0d, got %0d %0d %0d",
                     exp_rsp.found, exp_rsp.slot_index, exp_rsp.status,
                     rsp_item.found, rsp_item.slot_index, rsp_item.status);
            end
         end
      end
   end

   initial begin
      foreach (tree_used[i]) tree_used[i] = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_empty_and_extremes();
      test_remove_shapes();
      test_full_level();
      test_random(2000);
      req_valid = 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog sized for removes that lift large subtrees
   initial begin
      #200000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iabst_pkg.sv
rtl/iabst_ram.sv
rtl/implicit_array_bst_engine.sv
tb/implicit_array_bst_engine_tb.sv
